// ===== rtl/core/sfw_pkg.sv =====
// Shared types and constants for the screen fade/wipe sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sfw_pkg;

    localparam int STEPS_DEF  = 100;  // progress steps of a full run
    localparam int CNT_W      = 7;    // progress count width
    localparam int SPAN_W     = 8;    // holds 2*STEPS
    localparam int MS_W       = 16;   // millisecond fields
    localparam int DIM_W      = 12;   // screen dimensions
    localparam int EDGE_W     = 20;   // wipe edge fields
    localparam int DVD_W      = MS_W + 1;  // remainder + tick sum
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_W      = 96;   // 90 payload bits padded to bytes

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_REVERSE = 3'd1,
        CFG_PERIOD  = 3'd2,
        CFG_WIDTH   = 3'd3,
        CFG_HEIGHT  = 3'd4,
        CFG_DELAY   = 3'd5,
        CFG_KEEP    = 3'd6
    } sfw_cfg_t;

    typedef enum logic [0:0] {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } sfw_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_UPDATE,
        ST_EMIT
    } sfw_state_t;

    // Control from the sequencer; the FSM output block drives it.
    typedef struct packed {
        logic s_ready;
        logic div_start;
        logic commit;
        logic load_out;
    } sfw_ctl_t;

endpackage

// ===== rtl/core/sfw_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sfw_pkg for widths.
`timescale 1ns / 1ps

module sfw_divider (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start_i,
    input  logic [sfw_pkg::DVD_W-1:0] dividend_i,
    input  logic [sfw_pkg::MS_W-1:0]  divisor_i,
    output logic                     done_o,
    output logic [sfw_pkg::DVD_W-1:0] quotient_o,
    output logic [sfw_pkg::MS_W-1:0]  remainder_o
);
    import sfw_pkg::*;

    localparam int CNT_BITS = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]    quo_reg, quo_next;
    logic [MS_W-1:0]     rem_reg, rem_next;
    logic [MS_W-1:0]     dsr_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [MS_W:0] trial;
    logic [MS_W:0] diff;
    logic          ge;

    // Bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start_i) begin
            quo_next  = dividend_i;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start_i) begin
            dsr_reg <= divisor_i;
        end
    end

    assign done_o      = done_reg;
    assign quotient_o  = quo_reg;
    assign remainder_o = rem_reg;

endmodule

// ===== rtl/core/sfw_edge.sv =====
// Wipe edge products: dimension times progress and times (2*STEPS - progress).
// Depends on sfw_pkg for widths.
`timescale 1ns / 1ps

module sfw_edge #(
    parameter int STEPS = sfw_pkg::STEPS_DEF
) (
    input  logic [sfw_pkg::DIM_W-1:0]  width_i,
    input  logic [sfw_pkg::DIM_W-1:0]  height_i,
    input  logic [sfw_pkg::CNT_W-1:0]  count_i,
    output logic [sfw_pkg::EDGE_W-1:0] top_o,
    output logic [sfw_pkg::EDGE_W-1:0] bottom_o,
    output logic [sfw_pkg::EDGE_W-1:0] left_o,
    output logic [sfw_pkg::EDGE_W-1:0] right_o
);
    import sfw_pkg::*;

    localparam logic [SPAN_W-1:0] SPAN = SPAN_W'(2 * STEPS);

    logic [SPAN_W-1:0] rest;

    assign rest = SPAN - SPAN_W'(count_i);

    assign top_o    = EDGE_W'(height_i) * EDGE_W'(count_i);
    assign bottom_o = EDGE_W'(height_i) * EDGE_W'(rest);
    assign left_o   = EDGE_W'(width_i) * EDGE_W'(count_i);
    assign right_o  = EDGE_W'(width_i) * EDGE_W'(rest);

endmodule

// ===== rtl/core/screen_fade_wipe_sequencer_core.sv =====
// Top level of the screen fade/wipe sequencer: config registers, sequencer, output word.
// Depends on sfw_pkg, sfw_divider and sfw_edge.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): one word per event. s_tuser[0] is the op (0 tick,
//   1 start); s_tdata carries the elapsed milliseconds of a tick.
//   Output stream (m_*): exactly one result word per input word, in order.
//   Config channel (cfg_*): register index and data; always ready. Write only
//   while the block is idle. Index 0 (mode) is accepted but changes nothing,
//   since fade and wipe step identically.
//   Sequence: an active tick runs the remainder/period division through one
//   shared restoring divider, which produces 17 quotient bits; the divider's
//   done flag then moves the word to the update state, and the output state
//   loads the result word and raises m_tvalid. The next word is taken once
//   the sequencer is back in the idle state. A start or an idle tick skips
//   the divider and goes straight to the update and output states.
//   Throughput: one word in flight; s_tready is high only while idle. A
//   finished word waits in the output register, so the next word can be
//   accepted while the receiver stalls; that word then waits at its output
//   step until the register drains.
//   Reset (aresetn low, synchronous) clears progress, remainder, delay and
//   flags, loads the default registers, and drops m_tvalid.
module screen_fade_wipe_sequencer_core #(
    parameter int STEPS = sfw_pkg::STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfw_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sfw_pkg::MS_W-1:0]      s_tdata,  // [15:0] tick_ms
    input  logic [0:0]                    s_tuser,  // [0] op
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] running, [1] finished, [2] hold_black, [9:3] progress,
    // [29:10] top_edge, [49:30] bottom_edge, [69:50] left_edge,
    // [89:70] right_edge, [95:90] zero
    output logic [sfw_pkg::OUT_W-1:0]     m_tdata
);
    import sfw_pkg::*;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(STEPS);

    // ---------------- config registers ----------------
    logic              reverse_reg;
    logic [MS_W-1:0]   period_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [MS_W-1:0]   delay_cfg_reg;
    logic              keep_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_reg   <= 1'b0;
            period_reg    <= MS_W'(1);
            width_reg     <= DIM_W'(640);
            height_reg    <= DIM_W'(480);
            delay_cfg_reg <= '0;
            keep_reg      <= 1'b0;
        end else if (cfg_valid) begin
            unique case (sfw_cfg_t'(cfg_index))
                CFG_MODE:    ;  // mode has no effect on the outputs
                CFG_REVERSE: reverse_reg   <= cfg_data[0];
                CFG_PERIOD:  period_reg    <= cfg_data;
                CFG_WIDTH:   width_reg     <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:  height_reg    <= cfg_data[DIM_W-1:0];
                CFG_DELAY:   delay_cfg_reg <= cfg_data;
                CFG_KEEP:    keep_reg      <= cfg_data[0];
                default:     ;  // unmapped index, dropped
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    sfw_state_t      state_reg, state_next;
    sfw_ctl_t        ctl;

    logic [MS_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [MS_W-1:0]  delay_reg, delay_next;
    logic             active_reg, active_next;
    logic             hold_reg, hold_next;
    logic             done_reg, done_next;
    logic             op_reg;
    logic [MS_W-1:0]  ms_reg;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic             in_fire;
    logic             is_start;
    logic             div_done;
    logic [DVD_W-1:0] quot;
    logic [MS_W-1:0]  div_rem;
    logic [MS_W-1:0]  divisor;
    logic             out_free;

    assign in_fire  = s_tvalid && ctl.s_ready;
    assign is_start = (sfw_op_t'(s_tuser[0]) == OP_START);
    assign divisor  = (period_reg == '0) ? MS_W'(1) : period_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (is_start || !active_reg) ? ST_UPDATE : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output decode.
    always_comb begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ctl.s_ready   = 1'b1;
                ctl.div_start = s_tvalid && !is_start && active_reg;
            end
            ST_DIVIDE: ;
            ST_UPDATE: ctl.commit = 1'b1;
            ST_EMIT:   ctl.load_out = out_free;
            default:   ;
        endcase
    end

    assign s_tready = ctl.s_ready;

    sfw_divider u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_i     (ctl.div_start),
        .dividend_i  (DVD_W'(rem_reg) + DVD_W'(s_tdata)),
        .divisor_i   (divisor),
        .done_o      (div_done),
        .quotient_o  (quot),
        .remainder_o (div_rem)
    );

    // Progress update: a start word restarts the run; an active tick applies the finished division.
    logic [CNT_W-1:0] to_end;

    assign to_end = FULL - count_reg;

    always_comb begin
        rem_next    = rem_reg;
        count_next  = count_reg;
        delay_next  = delay_reg;
        active_next = active_reg;
        hold_next   = hold_reg;
        done_next   = 1'b0;
        if (sfw_op_t'(op_reg) == OP_START) begin
            count_next  = reverse_reg ? FULL : '0;
            delay_next  = delay_cfg_reg;
            active_next = 1'b1;
        end else if (active_reg) begin
            rem_next = div_rem;
            if (reverse_reg) begin
                delay_next = (ms_reg > delay_reg) ? '0 : (delay_reg - ms_reg);
            end
            // A pending reverse delay swallows the quotient.
            if (!(reverse_reg && (delay_next != '0)) && (quot != '0)) begin
                if (reverse_reg) begin
                    if (DVD_W'(count_reg) <= quot) begin
                        count_next = '0;
                        done_next  = 1'b1;
                    end else begin
                        count_next = count_reg - quot[CNT_W-1:0];
                    end
                end else begin
                    if (quot >= DVD_W'(to_end)) begin
                        count_next = FULL;
                        done_next  = 1'b1;
                    end else begin
                        count_next = count_reg + quot[CNT_W-1:0];
                    end
                end
                if (done_next) begin
                    active_next = 1'b0;
                    hold_next   = !reverse_reg && keep_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rem_reg    <= '0;
            count_reg  <= '0;
            delay_reg  <= '0;
            active_reg <= 1'b0;
            hold_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctl.commit) begin
                rem_reg    <= rem_next;
                count_reg  <= count_next;
                delay_reg  <= delay_next;
                active_reg <= active_next;
                hold_reg   <= hold_next;
                done_reg   <= done_next;
            end
        end
    end

    // Latch the accepted word.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg <= s_tuser[0];
            ms_reg <= s_tdata;
        end
    end

    // ---------------- output word ----------------
    logic [EDGE_W-1:0] top_e, bottom_e, left_e, right_e;

    sfw_edge #(
        .STEPS (STEPS)
    ) u_edge (
        .width_i  (width_reg),
        .height_i (height_reg),
        .count_i  (count_reg),
        .top_o    (top_e),
        .bottom_o (bottom_e),
        .left_o   (left_e),
        .right_o  (right_e)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            m_data_reg <= {6'd0, right_e, left_e, bottom_e, top_e,
                           count_reg, hold_reg, done_reg, active_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== sim/tb_screen_fade_wipe_sequencer_core.sv =====
// Testbench for screen_fade_wipe_sequencer_core: directed and random words checked
// against a cycle-free predictor kept in a small scoreboard class.
// Depends on sfw_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_screen_fade_wipe_sequencer_core;
    import sfw_pkg::*;

    localparam int STEPS       = STEPS_DEF;
    localparam int ITEM_TARGET = 1800;  // live words before stimulus stops
    localparam int HOLD_CYCLES = 250;   // one long receiver hold-off
    localparam int IDLE_LIMIT  = 3000;  // cycles without any handshake
    localparam int TAIL_CYCLES = 60;    // idle wait after the final settle
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // unmapped index

    // Result word layout, lowest bit last in the list.
    typedef struct packed {
        logic [OUT_W-91:0]  spare;
        logic [EDGE_W-1:0]  right_edge;
        logic [EDGE_W-1:0]  left_edge;
        logic [EDGE_W-1:0]  bottom_edge;
        logic [EDGE_W-1:0]  top_edge;
        logic [CNT_W-1:0]   progress;
        logic               hold_black;
        logic               finished;
        logic               running;
    } fade_result_t;

    // Tracks registers and transition state; queues the word each input should produce.
    class fade_sequence_scoreboard;
        bit              mode_reg, reverse_reg, keep_reg;
        bit [15:0]       period_reg, delay_reg;
        bit [11:0]       width_reg, height_reg;
        bit [15:0]       remainder, delay_left;
        bit [CNT_W-1:0]  progress;
        bit              running, hold_black;
        fade_result_t    expected_q[$];
        int              mismatches, checked, fwd_done, rev_done, reg_writes;

        function new();
            period_reg = 1;
            width_reg  = 640;
            height_reg = 480;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            reg_writes++;
            case (idx)
                CFG_MODE:    mode_reg    = data[0];
                CFG_REVERSE: reverse_reg = data[0];
                CFG_PERIOD:  period_reg  = data;
                CFG_WIDTH:   width_reg   = data[11:0];
                CFG_HEIGHT:  height_reg  = data[11:0];
                CFG_DELAY:   delay_reg   = data;
                CFG_KEEP:    keep_reg    = data[0];
                default: ;
            endcase
        endfunction

        function void note_word(sfw_op_t op, logic [15:0] ms);
            fade_result_t want;
            int unsigned  per, acc, steps_due, h, w, p, q;
            bit           advance, done;
            done = 0;
            if (op == OP_START) begin
                progress   = reverse_reg ? CNT_W'(STEPS) : '0;
                delay_left = delay_reg;
                running    = 1;
            end else if (running) begin
                per       = (period_reg == 0) ? 1 : period_reg;  // zero period acts as 1
                acc       = remainder + ms;
                steps_due = acc / per;
                remainder = 16'(acc % per);
                advance   = 1;
                if (reverse_reg) begin
                    // delay burns down first; quotient is dropped while any remains
                    delay_left = (ms > delay_left) ? '0 : delay_left - ms;
                    if (delay_left != 0) advance = 0;
                end
                if (advance && steps_due != 0) begin
                    if (reverse_reg) begin
                        if (progress <= steps_due) begin
                            progress = '0;
                            done     = 1;
                        end else begin
                            progress = CNT_W'(progress - steps_due);
                        end
                    end else if (steps_due >= STEPS - progress) begin
                        progress = CNT_W'(STEPS);
                        done     = 1;
                    end else begin
                        progress = CNT_W'(progress + steps_due);
                    end
                    if (done) begin
                        running    = 0;
                        hold_black = !reverse_reg && keep_reg;
                        if (reverse_reg) rev_done++;
                        else fwd_done++;
                    end
                end
            end
            h = height_reg;
            w = width_reg;
            p = progress;
            q = 2 * STEPS - p;
            want             = '0;
            want.running     = running;
            want.finished    = done;
            want.hold_black  = hold_black;
            want.progress    = progress;
            want.top_edge    = EDGE_W'(h * p);
            want.bottom_edge = EDGE_W'(h * q);
            want.left_edge   = EDGE_W'(w * p);
            want.right_edge  = EDGE_W'(w * q);
            expected_q.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0d, expected %0d",
                                 checked, name, got, want));
        endtask

        task check_word(logic [OUT_W-1:0] word);
            fade_result_t got, want;
            got = word;
            if (expected_q.size() == 0) begin
                report($sformatf("result word %h arrived with nothing expected", word));
                return;
            end
            want = expected_q.pop_front();
            compare_field("running",     got.running,     want.running);
            compare_field("finished",    got.finished,    want.finished);
            compare_field("hold_black",  got.hold_black,  want.hold_black);
            compare_field("progress",    got.progress,    want.progress);
            compare_field("top_edge",    got.top_edge,    want.top_edge);
            compare_field("bottom_edge", got.bottom_edge, want.bottom_edge);
            compare_field("left_edge",   got.left_edge,   want.left_edge);
            compare_field("right_edge",  got.right_edge,  want.right_edge);
            compare_field("padding",     got.spare,       want.spare);
            checked++;
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [MS_W-1:0]       s_tdata   = '0;   // [15:0] tick_ms
    logic [0:0]            s_tuser   = '0;   // [0] op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;          // see fade_result_t

    fade_sequence_scoreboard sb = new();

    bit calm;        // last stretch: no idling on either side
    bit hold_req;    // asks the receiver for its long hold-off
    bit hold_done;
    int live_words;  // words that start a transition or arrive while one runs

    screen_fade_wipe_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Result side: every accepted word goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any handshake restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] timeout: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("** screen_fade_wipe_sequencer_core: FAILED **");
        $finish;
    end

    // Offer one word, leaving s_tvalid high on return so a follow-on word
    // can go back to back. Any config valid still high is dropped here.
    task automatic send(sfw_op_t op, logic [15:0] ms);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ms;
        do @(posedge aclk); while (!s_tready);
        if (op == OP_START || sb.running) live_words++;
        sb.note_word(op, ms);
    endtask

    // Leaves cfg_valid high; the next send or settle lowers it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Stop offering and wait until every outstanding result has drained.
    task automatic settle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
    endtask

    function automatic logic [15:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx);
        case (idx)
            CFG_PERIOD:
                case ($urandom_range(0, 9))
                    0:       return '0;
                    1:       return 16'hFFFF;
                    2:       return 16'($urandom);
                    default: return 16'($urandom_range(1, 40));
                endcase
            CFG_WIDTH, CFG_HEIGHT:
                case ($urandom_range(0, 9))
                    0:       return 16'd4095;
                    1:       return 16'd1;
                    2:       return 16'($urandom);  // upper bits must be ignored
                    3:       return '0;
                    default: return 16'($urandom_range(1, 4095));
                endcase
            CFG_DELAY:
                case ($urandom_range(0, 7))
                    0:       return '0;
                    1:       return 16'($urandom);
                    default: return 16'($urandom_range(0, 300));
                endcase
            default:
                return ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 1));
        endcase
    endfunction

    // Tick sizes scaled to the current period so runs actually finish.
    function automatic logic [15:0] pick_tick();
        int unsigned per, bound;
        per = (sb.period_reg == 0) ? 1 : sb.period_reg;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'($urandom);
            2:       return 16'hFFFF;
            default: begin
                bound = per * $urandom_range(1, 25);
                if (bound > 16'hFFFF) bound = 16'hFFFF;
                return 16'($urandom_range(0, bound));
            end
        endcase
    endfunction

    initial begin
        int n_ticks;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults: forward, period 1. Idle tick first, then exact landing on the end.
        send(OP_TICK,  16'hFFFF);
        send(OP_START, 16'hFFFF);    // tick_ms ignored on start
        send(OP_TICK,  16'd0);
        send(OP_TICK,  16'd50);
        send(OP_TICK,  16'd49);
        send(OP_TICK,  16'd1);       // completes
        send(OP_TICK,  16'd7);       // idle again

        // Zero period, keep-black, largest screen: one tick overshoots to the end.
        settle();
        write_reg(CFG_PERIOD, 16'd0);
        write_reg(CFG_KEEP,   16'd1);
        write_reg(CFG_WIDTH,  16'd4095);
        write_reg(CFG_HEIGHT, 16'd4095);
        write_reg(CFG_MODE,   16'd1);
        send(OP_START, 16'd0);
        send(OP_TICK,  16'hFFFF);

        // Reverse with a short delay, smallest screen; keep must not apply.
        settle();
        write_reg(CFG_REVERSE, 16'd1);
        write_reg(CFG_PERIOD,  16'd3);
        write_reg(CFG_DELAY,   16'd5);
        write_reg(CFG_WIDTH,   16'd1);
        write_reg(CFG_HEIGHT,  16'd1);
        send(OP_START, 16'd0);
        send(OP_TICK,  16'd4);       // delay not yet spent, steps discarded
        send(OP_TICK,  16'd1);       // delay hits zero
        send(OP_TICK,  16'd298);

        // Longest period and delay, then a restart in mid-run.
        settle();
        write_reg(CFG_PERIOD, 16'hFFFF);
        write_reg(CFG_DELAY,  16'hFFFF);
        send(OP_START, 16'd0);
        send(OP_TICK,  16'hFFFF);
        send(OP_TICK,  16'hFFFF);
        send(OP_START, 16'd0);

        // Unmapped index must be harmless; back to forward with no keep.
        settle();
        write_reg(CFG_SPARE,   16'hFFFF);
        write_reg(CFG_REVERSE, 16'd0);
        write_reg(CFG_KEEP,    16'd0);
        write_reg(CFG_PERIOD,  16'd1);
        write_reg(CFG_MODE,    16'd0);
        send(OP_START, 16'd0);
        send(OP_TICK,  16'hFFFF);

        // Random part: mostly reconfigure-start-tick runs, some raw noise.
        while (live_words < ITEM_TARGET) begin
            calm = (live_words >= ITEM_TARGET * 17 / 20);
            if ($urandom_range(0, 9) < 2) begin
                repeat ($urandom_range(1, 8))
                    send($urandom_range(0, 1) ? OP_START : OP_TICK, 16'($urandom));
            end else begin
                settle();
                for (int i = 0; i <= CFG_KEEP; i++)
                    if ($urandom_range(0, 2) == 0) write_reg(3'(i), pick_reg_value(3'(i)));
                // sometimes keep a live run going under the new registers
                if (!sb.running || $urandom_range(0, 3) != 0)
                    send(OP_START, 16'($urandom));
                if (!hold_done && live_words >= 400) begin
                    // receiver stalls long while words keep coming: input must back up
                    hold_req  = 1;
                    hold_done = 1;
                    repeat (6) send(OP_TICK, pick_tick());
                end
                n_ticks = $urandom_range(5, 60);
                do begin
                    send(OP_TICK, pick_tick());
                    n_ticks--;
                end while (sb.running && n_ticks > 0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d live words, %0d results checked, %0d register writes.",
                 live_words, sb.checked, sb.reg_writes);
        $display("Transitions completed: %0d forward, %0d reverse; %0d mismatches.",
                 sb.fwd_done, sb.rev_done, sb.mismatches);
        if (sb.mismatches == 0)
            $display("** screen_fade_wipe_sequencer_core: PASSED **");
        else
            $display("** screen_fade_wipe_sequencer_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sfw_pkg.sv
rtl/core/sfw_divider.sv
rtl/core/sfw_edge.sv
rtl/core/screen_fade_wipe_sequencer_core.sv
sim/tb_screen_fade_wipe_sequencer_core.sv
